// ===== rtl/uripd_pkg.sv =====
// Shared types, status codes and character-class functions for the URI
// percent decoder. No dependencies.
`default_nettype none

package uripd_pkg;

    typedef struct packed {
        logic [7:0] in_byte;
        logic       in_last;
        logic [1:0] mode;
    } t_in_word;

    typedef struct packed {
        logic [7:0] out_byte;
        logic       out_last;
        logic [1:0] status;
        logic       out_empty;
    } t_out_word;

    // decode result handed from the decode stage to the result register
    typedef struct packed {
        logic      vld;
        t_out_word word;
    } t_dec_result;

    typedef enum logic [1:0] {
        ESC_IDLE = 2'd0,
        ESC_HI   = 2'd1,
        ESC_LO   = 2'd2
    } t_esc_phase;

    localparam logic [1:0] ST_OK       = 2'd0;
    localparam logic [1:0] ST_BAD_CHAR = 2'd1;
    localparam logic [1:0] ST_BAD_HEX  = 2'd2;
    localparam logic [1:0] ST_TRUNC    = 2'd3;

    localparam logic [1:0] MODE_QPARAM   = 2'd0;
    localparam logic [1:0] MODE_USERINFO = 2'd1;
    localparam logic [1:0] MODE_HOSTPATH = 2'd2;
    localparam logic [1:0] MODE_FRAGMENT = 2'd3;

    localparam logic [7:0] CH_PERCENT = 8'h25;
    localparam logic [7:0] CH_PLUS    = 8'h2B;
    localparam logic [7:0] CH_SPACE   = 8'h20;

    function automatic logic userinfo_ok(input logic [7:0] c);
        logic ok;
        ok = 1'b0;
        case (c) inside
            [8'h61:8'h7A], [8'h41:8'h5A], [8'h30:8'h39]: ok = 1'b1;
            // - . _ =
            8'h2D, 8'h2E, 8'h5F, 8'h3D: ok = 1'b1;
            // ! $ & ' ( ) * + , ;
            8'h21, 8'h24, 8'h26, 8'h27, 8'h28, 8'h29,
            8'h2A, 8'h2B, 8'h2C, 8'h3B: ok = 1'b1;
            default: ok = 1'b0;
        endcase
        return ok;
    endfunction

    function automatic logic fragment_ok(input logic [7:0] c);
        logic ok;
        ok = 1'b0;
        case (c) inside
            // : @ / ?
            8'h3A, 8'h40, 8'h2F, 8'h3F: ok = 1'b1;
            default: ok = userinfo_ok(c);
        endcase
        return ok;
    endfunction

    // bit 4 set means not a hex digit
    function automatic logic [4:0] hex_value(input logic [7:0] c);
        logic [4:0] v;
        v = 5'h10;
        case (c) inside
            [8'h30:8'h39]: v = {1'b0, 4'(c - 8'h30)};
            [8'h61:8'h66]: v = {1'b0, 4'(c - 8'h57)};
            [8'h41:8'h46]: v = {1'b0, 4'(c - 8'h37)};
            default:       v = 5'h10;
        endcase
        return v;
    endfunction

endpackage

`default_nettype wire

// ===== rtl/uripd_decode.sv =====
// Per-byte decode step: escape and skip state registers plus the
// combinational decision for one word. Depends on uripd_pkg.
`default_nettype none

module uripd_decode (
    input  wire logic                  i_clk,
    input  wire logic                  i_rst_n,
    input  wire logic                  i_adv,
    input  wire uripd_pkg::t_in_word   i_word,
    output uripd_pkg::t_dec_result     o_res
);
    import uripd_pkg::*;

    t_esc_phase r_phase, n_phase;
    logic [3:0] r_hi_nib, n_hi_nib;
    logic       r_skip, n_skip;

    logic [7:0] c;
    logic       last;
    logic [1:0] mode;
    logic [4:0] hv;

    assign c    = i_word.in_byte;
    assign last = i_word.in_last;
    assign mode = i_word.mode;
    assign hv   = hex_value(c);

    always_comb begin
        n_phase  = r_phase;
        n_hi_nib = r_hi_nib;
        n_skip   = r_skip;
        o_res    = '0;

        if (r_skip) begin
            if (last) begin
                n_skip   = 1'b0;
                n_phase  = ESC_IDLE;
                n_hi_nib = '0;
            end
        end else if (r_phase == ESC_HI || r_phase == ESC_LO) begin
            if (hv[4]) begin
                n_phase              = ESC_IDLE;
                n_hi_nib             = '0;
                n_skip               = !last;
                o_res.vld            = 1'b1;
                o_res.word.out_last  = 1'b1;
                o_res.word.status    = ST_BAD_HEX;
            end else if (r_phase == ESC_HI) begin
                if (last) begin
                    n_phase             = ESC_IDLE;
                    n_hi_nib            = '0;
                    o_res.vld           = 1'b1;
                    o_res.word.out_last = 1'b1;
                    o_res.word.status   = ST_TRUNC;
                end else begin
                    n_hi_nib = hv[3:0];
                    n_phase  = ESC_LO;
                end
            end else begin
                n_phase             = ESC_IDLE;
                n_hi_nib            = '0;
                o_res.vld           = 1'b1;
                o_res.word.out_byte = {r_hi_nib, hv[3:0]};
                o_res.word.out_last = last;
                o_res.word.status   = ST_OK;
            end
        end else begin
            // idle (phase three is never reached and acts as idle)
            n_phase = ESC_IDLE;
            if ((mode == MODE_USERINFO && userinfo_ok(c)) ||
                (mode == MODE_FRAGMENT && fragment_ok(c))) begin
                o_res.vld           = 1'b1;
                o_res.word.out_byte = c;
                o_res.word.out_last = last;
            end else if (c == CH_PERCENT) begin
                if (last) begin
                    n_hi_nib            = '0;
                    o_res.vld           = 1'b1;
                    o_res.word.out_last = 1'b1;
                    o_res.word.status   = ST_TRUNC;
                end else begin
                    n_phase = ESC_HI;
                end
            end else if (mode == MODE_USERINFO || mode == MODE_FRAGMENT) begin
                n_hi_nib            = '0;
                n_skip              = !last;
                o_res.vld           = 1'b1;
                o_res.word.out_last = 1'b1;
                o_res.word.status   = ST_BAD_CHAR;
            end else begin
                o_res.vld           = 1'b1;
                o_res.word.out_byte = (mode == MODE_QPARAM && c == CH_PLUS) ? CH_SPACE : c;
                o_res.word.out_last = last;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase  <= ESC_IDLE;
            r_hi_nib <= '0;
            r_skip   <= 1'b0;
        end else if (i_adv) begin
            r_phase  <= n_phase;
            r_hi_nib <= n_hi_nib;
            r_skip   <= n_skip;
        end
    end

endmodule

`default_nettype wire

// ===== rtl/uri_percent_decoder.sv =====
// URI component percent decoder top level: input register, decode step,
// result register. Depends on uripd_pkg and uripd_decode.
//
// Usage:
//   Input channel (i_in_valid / o_in_ready / i_in_word) carries one raw byte
//   of a URI component per word, with in_last on the final byte and the mode
//   (query param, userinfo, host/path, query/fragment) alongside.
//   Output channel (o_out_valid / i_out_ready / o_out_word) gives at most one
//   result word per input word: a decoded byte, or an error word with
//   out_last set. '%' and the first hex digit of an escape give no word;
//   after an error the rest of the string is dropped silently.
//   Path: an accepted word passes the input register, the decode step and
//   then the result register. Throughput: one word per cycle while
//   i_out_ready stays high, set by the combinational decode between the
//   two registers. While a result waits, the input register still takes
//   one more word, which then holds until the result register frees up.
//   Stall: when the receiver holds i_out_ready low with a result pending,
//   the input register fills and o_in_ready drops; nothing is lost.
//   Reset: synchronous active-low i_rst_n empties both registers and clears
//   the escape and skip state.
`default_nettype none

module uri_percent_decoder (
    input  wire logic                 i_clk,
    input  wire logic                 i_rst_n,
    input  wire logic                 i_in_valid,
    output logic                      o_in_ready,
    input  wire uripd_pkg::t_in_word  i_in_word,
    output logic                      o_out_valid,
    input  wire logic                 i_out_ready,
    output uripd_pkg::t_out_word      o_out_word
);
    import uripd_pkg::*;

    logic        r_in_vld;
    t_in_word    r_in_word;
    logic        r_out_vld;
    t_out_word   r_out_word;

    logic        out_free;
    logic        adv;
    t_dec_result dec_res;

    assign out_free   = !r_out_vld || i_out_ready;
    assign adv        = r_in_vld && out_free;
    assign o_in_ready = !r_in_vld || adv;

    uripd_decode u_decode (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_adv   (adv),
        .i_word  (r_in_word),
        .o_res   (dec_res)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_vld <= 1'b0;
        end else if (o_in_ready) begin
            r_in_vld <= i_in_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_in_ready && i_in_valid) begin
            r_in_word <= i_in_word;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_vld <= 1'b0;
        end else if (out_free) begin
            r_out_vld <= adv && dec_res.vld;
        end
    end

    always_ff @(posedge i_clk) begin
        if (adv && dec_res.vld && out_free) begin
            r_out_word <= dec_res.word;
        end
    end

    assign o_out_valid = r_out_vld;
    assign o_out_word  = r_out_word;

endmodule

`default_nettype wire
